/* sv/tss_pkg.sv */
// Shared constants, codes and types of the tone sweep step sequencer.
package tss_pkg;

  localparam int TSS_QUEUE_DEPTH = 32;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_UPDATE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] JOB_ADD    = 2'd0;
  localparam logic [1:0] JOB_UPDATE = 2'd1;
  localparam logic [1:0] JOB_CLEAR  = 2'd2;
  localparam logic [1:0] JOB_NOP    = 2'd3;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_TONE    = 2'd1;
  localparam logic [1:0] ACT_SILENCE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] start_freq;
    logic [15:0] end_freq;
    logic [15:0] duration_ms;
    logic [31:0] now_ms;
  } tss_job_t;

endpackage

/* sv/tss_cmd_if.sv */
// Command channel: valid, ready and the fields of one incoming word.
interface tss_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] start_freq;
  logic [15:0] end_freq;
  logic [15:0] duration_ms;
  logic [31:0] now_ms;

  modport source (output valid, func, start_freq, end_freq, duration_ms, now_ms,
                  input ready);
  modport sink (input valid, func, start_freq, end_freq, duration_ms, now_ms,
                output ready);
endinterface

/* sv/tss_res_if.sv */
// Result channel: valid, ready and the fields of one outgoing word.
interface tss_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] freq;
  logic        busy_res;
  logic        dropped;

  modport source (output valid, action, freq, busy_res, dropped, input ready);
  modport sink (input valid, action, freq, busy_res, dropped, output ready);
endinterface

/* sv/tss_front.sv */
// Front end: accepts command words, classifies them and queues them for the back end.
module tss_front import tss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  tss_cmd_if.sink  cmd,
  output tss_job_t job,
  output logic     job_valid,
  input  logic     job_ready
);

  tss_job_t   slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic [1:0] kind;
  logic       push;
  logic       pop;

  always_comb begin
    case (cmd.func)
      FUNC_ADD:    kind = JOB_ADD;
      FUNC_UPDATE: kind = JOB_UPDATE;
      FUNC_CLEAR:  kind = JOB_CLEAR;
      default:     kind = JOB_NOP;
    endcase
  end

  assign cmd.ready = (fill != 2'd2);
  assign push      = cmd.valid && cmd.ready;
  assign job_valid = (fill != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{kind:        kind,
                        start_freq:  cmd.start_freq,
                        end_freq:    cmd.end_freq,
                        duration_ms: cmd.duration_ms,
                        now_ms:      cmd.now_ms};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

/* sv/tss_back.sv */
// Back end: step store, play sequencing and the serial sweep divider.
module tss_back import tss_pkg::*; #(
  parameter  int QUEUE_DEPTH = TSS_QUEUE_DEPTH,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  tss_job_t      job,
  input  logic          job_valid,
  output logic          job_ready,
  tss_res_if.source     res,
  output logic [CW-1:0] qcount,
  output logic [CW-1:0] ppos
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [47:0] mem [QUEUE_DEPTH];
  logic [47:0] rd_data;
  logic        mem_we;

  logic [2:0]  state;
  logic        started;
  logic [31:0] begin_time;
  logic [31:0] now_r;
  logic [15:0] s0_r;
  logic [15:0] diff_mag;
  logic        neg;
  logic [15:0] el_r;
  logic [15:0] dur_r;
  logic [31:0] dq;
  logic [16:0] rem;
  logic [3:0]  div_cnt;
  logic [1:0]  act_r;
  logic [15:0] freq_r;
  logic        drop_r;

  logic        out_valid;
  logic [1:0]  out_action;
  logic [15:0] out_freq;
  logic        out_busy;
  logic        out_dropped;

  logic [15:0] s0;
  logic [15:0] s1;
  logic [15:0] dur;
  logic [31:0] elapsed;
  logic        expired;
  logic [16:0] rem_next;
  logic [31:0] dq_next;
  logic        out_free;

  function automatic logic [48:0] div_step(logic [16:0] r, logic [31:0] q, logic [15:0] d);
    logic [16:0] t;
    logic        b;
    t = {r[15:0], q[31]};
    b = (t >= {1'b0, d});
    if (b) begin
      t = t - {1'b0, d};
    end
    return {t, q[30:0], b};
  endfunction

  assign s0      = rd_data[47:32];
  assign s1      = rd_data[31:16];
  assign dur     = rd_data[15:0];
  assign elapsed = now_r - begin_time;
  assign expired = (elapsed >= {16'd0, dur});
  assign mem_we  = (state == ST_IDLE) && job_valid && (job.kind == JOB_ADD) &&
                   (qcount < CW'(QUEUE_DEPTH));
  assign job_ready = (state == ST_IDLE);
  assign out_free  = !out_valid || res.ready;

  always_comb begin
    logic [48:0] a;
    logic [48:0] b;
    a = div_step(rem, dq, dur_r);
    b = div_step(a[48:32], a[31:0], dur_r);
    rem_next = b[48:32];
    dq_next  = b[31:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[qcount[AW-1:0]] <= {job.start_freq, job.end_freq, job.duration_ms};
    end
    rd_data <= mem[ppos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      qcount     <= '0;
      ppos       <= '0;
      started    <= 1'b0;
      begin_time <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && res.ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            act_r  <= ACT_NONE;
            freq_r <= 16'd0;
            drop_r <= 1'b0;
            state  <= ST_FIN;
            case (job.kind)
              JOB_ADD: begin
                if (qcount < CW'(QUEUE_DEPTH)) begin
                  qcount <= qcount + CW'(1);
                end else begin
                  drop_r <= 1'b1;
                end
              end
              JOB_CLEAR: begin
                act_r      <= ACT_SILENCE;
                qcount     <= '0;
                ppos       <= '0;
                started    <= 1'b0;
                begin_time <= '0;
              end
              JOB_UPDATE: begin
                if (ppos >= qcount) begin
                  if (qcount != '0) begin
                    act_r      <= ACT_SILENCE;
                    qcount     <= '0;
                    ppos       <= '0;
                    started    <= 1'b0;
                    begin_time <= '0;
                  end
                end else begin
                  now_r <= job.now_ms;
                  state <= ST_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_FIN;
          if (!started) begin
            act_r      <= (s0 == 16'd0) ? ACT_SILENCE : ACT_TONE;
            freq_r     <= s0;
            started    <= 1'b1;
            begin_time <= now_r;
          end else if (expired) begin
            ppos       <= ppos + CW'(1);
            started    <= 1'b0;
            begin_time <= '0;
          end else if ((s0 != s1) && (s0 != 16'd0)) begin
            s0_r     <= s0;
            neg      <= (s1 < s0);
            diff_mag <= (s1 < s0) ? (s0 - s1) : (s1 - s0);
            el_r     <= elapsed[15:0];
            dur_r    <= dur;
            state    <= ST_MUL;
          end
        end
        ST_MUL: begin
          dq      <= {16'd0, diff_mag} * {16'd0, el_r};
          rem     <= '0;
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          dq      <= dq_next;
          rem     <= rem_next;
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd15) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          act_r  <= ACT_TONE;
          freq_r <= neg ? (s0_r - dq[15:0]) : (s0_r + dq[15:0]);
          state  <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_action  <= act_r;
            out_freq    <= freq_r;
            out_busy    <= (ppos < qcount);
            out_dropped <= drop_r;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign res.valid    = out_valid;
  assign res.action   = out_action;
  assign res.freq     = out_freq;
  assign res.busy_res = out_busy;
  assign res.dropped  = out_dropped;

endmodule

/* sv/tone_sweep_step_sequencer.sv */
// Top level of the tone sweep step sequencer: front end, command queue and back end.
//
//   port  role    word
//   cmd   sink    func, start_freq, end_freq, duration_ms, now_ms
//   res   source  action, freq, busy_res, dropped
//
// A word waits in the front queue; add, clear and an update with nothing left to play go from
// idle straight to the result state, any other update without a sweep passes the read state,
// and a sweep update passes read, multiply, divide and sum, using the two-bit-per-cycle divider.
// Reset is synchronous; the step store is not cleared and needs no clearing pass.
// A stalled result holds the back end, which then fills the two-word front queue.
module tone_sweep_step_sequencer import tss_pkg::*; #(
  parameter int QUEUE_DEPTH = TSS_QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  tss_cmd_if.sink    cmd,
  tss_res_if.source  res
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tss_job_t      job;
  logic          job_valid;
  logic          job_ready;
  logic [CW-1:0] qcount;
  logic [CW-1:0] ppos;

  tss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready)
  );

  tss_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .res       (res),
    .qcount    (qcount),
    .ppos      (ppos)
  );

  a_pos_in_queue: assert property (@(posedge clk) disable iff (rst) ppos <= qcount)
    else $error("play position beyond queued count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    qcount <= CW'(QUEUE_DEPTH))
    else $error("queued count beyond queue depth");

  a_tone_nonzero: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.action == ACT_TONE) |-> res.freq != 16'd0)
    else $error("tone driven at zero frequency");

endmodule
